// ----- sv/particle_number_density_classifier_defines.svh -----
// assertion macros for the density classifier
`ifndef PARTICLE_NUMBER_DENSITY_CLASSIFIER_DEFINES_SVH
`define PARTICLE_NUMBER_DENSITY_CLASSIFIER_DEFINES_SVH

// condition that holds at every edge out of reset
`define PNDC_CHECK(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("pndc check failed");

// implication checked in the same cycle
`define PNDC_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pndc implication failed");

// implication checked in the next cycle
`define PNDC_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pndc next-cycle check failed");

`endif

// ----- sv/pndc_pkg.sv -----
`default_nettype none
package pndc_pkg;

	// defaults for the top level parameters
	localparam int MAX_PARTICLES_DEF = 1024;
	localparam int POSITION_BITS_DEF = 24;

	// fixed field widths
	localparam int RADIUS_BITS = 23;
	localparam int DENS_BITS   = 24;
	localparam int GAIN_BITS   = 32;
	localparam int SRC_BITS    = 48;
	localparam int QUOT_BITS   = RADIUS_BITS + 16;
	localparam int SQ_BITS     = 2 * RADIUS_BITS;

	// register reset values
	localparam logic [RADIUS_BITS-1:0] RADIUS_RST    = 23'd88080;
	localparam logic [DENS_BITS-1:0]   BASE_DENS_RST = 24'd428585;
	localparam logic [DENS_BITS-1:0]   SURF_THR_RST  = 24'd415727;
	localparam logic [GAIN_BITS-1:0]   GAIN_RST      = 32'd0;

	localparam logic [DENS_BITS-1:0] DENS_MAX = 24'hFFFFFF;
	localparam logic [QUOT_BITS-1:0] ONE_Q16  = 39'd65536;

	// register indexes
	localparam logic [1:0] REG_RADIUS    = 2'd0;
	localparam logic [1:0] REG_BASE_DENS = 2'd1;
	localparam logic [1:0] REG_SURF_THR  = 2'd2;
	localparam logic [1:0] REG_GAIN      = 2'd3;

	// commands
	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	// particle kinds
	localparam logic [1:0] KIND_DUMMY = 2'd2;
	localparam logic [1:0] KIND_GHOST = 2'd3;

	// classes
	localparam logic [1:0] CLS_NONE    = 2'd0;
	localparam logic [1:0] CLS_INNER   = 2'd1;
	localparam logic [1:0] CLS_SURFACE = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ME, ST_RD, ST_CHK, ST_SUM, ST_SQRT, ST_DIV,
		ST_WGT, ST_ACC, ST_FIN, ST_SRC, ST_OUT
	} st_t;

endpackage
`default_nettype wire

// ----- sv/pndc_ram.sv -----
`default_nettype none
module pndc_ram #(
	parameter int WIDTH = 50,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- sv/particle_number_density_classifier.sv -----
// channel   signals                                  direction
// input     in_valid in_stall cmd slot pos_x pos_y kind   in
// result    out_valid out_stall density boundary_class
//           source_term bad_index                     out
// config    cfg_valid cfg_ready cfg_index cfg_data     in
//
// clear, append and cmd 3 are handled in the idle state; a query reads its own entry, then
// one store entry per pass: read and check when skipped, also a squared sum when outside
// the radius or coincident, a 23-step square root and 39-step divider for a neighbor;
// then it classifies, forms the source term and loads the output register.
// reset empties the store count and loads the register defaults; no clearing pass.
// a waiting result holds in the output register; the block stalls input only while busy.
// configuration is taken only while no query is in flight.
`default_nettype none
`include "particle_number_density_classifier_defines.svh"
module particle_number_density_classifier
	import pndc_pkg::*;
#(
	parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [1:0]                  cmd,
	input  wire logic [9:0]                  slot,
	input  wire logic [POSITION_BITS-1:0]    pos_x,
	input  wire logic [POSITION_BITS-1:0]    pos_y,
	input  wire logic [1:0]                  kind,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [DENS_BITS-1:0]             density,
	output logic [1:0]                       boundary_class,
	output logic signed [SRC_BITS-1:0]       source_term,
	output logic                             bad_index,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [31:0]                 cfg_data
);

	localparam int P  = POSITION_BITS;
	localparam int AW = $clog2(MAX_PARTICLES);
	localparam int CW = $clog2(MAX_PARTICLES + 1);
	localparam int EW = 2 * P + 2;
	localparam logic [4:0] SQ_LAST  = 5'(RADIUS_BITS - 1);
	localparam logic [5:0] DIV_LAST = 6'(QUOT_BITS - 1);

	// configuration registers
	logic [RADIUS_BITS-1:0] radius_q;
	logic [DENS_BITS-1:0]   base_q;
	logic [DENS_BITS-1:0]   thr_q;
	logic [GAIN_BITS-1:0]   gain_q;
	logic [SQ_BITS-1:0]     r2_q;

	// control state
	st_t           st_q, st_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] j_q;
	logic [AW-1:0] slot_q;
	logic          out_valid_q;

	// working registers
	logic [P-1:0]           me_x_q, me_y_q;
	logic [1:0]             me_kind_q;
	logic [SQ_BITS-1:0]     sqx_s2, sqy_s2;
	logic [SQ_BITS-1:0]     rad_q;
	logic [25:0]            srem_q;
	logic [RADIUS_BITS-1:0] root_q;
	logic [4:0]             scnt_q;
	logic [QUOT_BITS-1:0]   dv_q;
	logic [23:0]            drem_q;
	logic [5:0]             dcnt_q;
	logic [DENS_BITS-1:0]   weight_q;
	logic [DENS_BITS-1:0]   dens_q;
	logic [1:0]             cls_q;
	logic                   neg_q;
	logic [55:0]            prod_s;
	logic signed [SRC_BITS-1:0] src_q;
	logic                   bad_q;

	// output registers
	logic [DENS_BITS-1:0]       density_q;
	logic [1:0]                 class_q;
	logic signed [SRC_BITS-1:0] source_q;
	logic                       bad_out_q;

	// memory ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0] ram_wdata, ram_rdata;

	logic          in_acc;
	logic [31:0]   slot_w;
	logic          slot_ok;

	// neighbor check signals
	logic [P-1:0]    nb_x, nb_y;
	logic [1:0]      nb_kind;
	logic signed [P:0] dxs, dys;
	logic [P:0]      ax, ay;
	logic [32:0]     ax_w, ay_w;
	logic            skip;
	logic [SQ_BITS:0] d2;

	// iteration step signals
	logic [25:0]            srem_n, strial;
	logic [24:0]            drem_n;
	logic [QUOT_BITS-1:0]   wq;
	logic [DENS_BITS:0]     acc_sum;
	logic [DENS_BITS-1:0]   diff;
	logic [56:0]            prod_r;
	logic [40:0]            mag;

	pndc_ram #(.WIDTH(EW), .DEPTH(MAX_PARTICLES)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_acc  = in_valid && !in_stall;
	assign slot_w  = 32'(slot);
	assign slot_ok = slot_w < 32'(count_q);

	// neighbor distance terms
	always_comb begin
		nb_x    = ram_rdata[EW-1:P+2];
		nb_y    = ram_rdata[P+1:2];
		nb_kind = ram_rdata[1:0];
		dxs     = $signed({me_x_q[P-1], me_x_q}) - $signed({nb_x[P-1], nb_x});
		dys     = $signed({me_y_q[P-1], me_y_q}) - $signed({nb_y[P-1], nb_y});
		ax      = dxs[P] ? (P+1)'(-dxs) : (P+1)'(dxs);
		ay      = dys[P] ? (P+1)'(-dys) : (P+1)'(dys);
		ax_w    = 33'(ax);
		ay_w    = 33'(ay);
		skip    = (32'(j_q) == 32'(slot_q)) || (nb_kind == KIND_GHOST) ||
			(ax_w >= 33'(radius_q)) || (ay_w >= 33'(radius_q));
		d2      = (SQ_BITS+1)'(sqx_s2) + (SQ_BITS+1)'(sqy_s2);
	end

	// square root and divider steps
	always_comb begin
		srem_n = {srem_q[23:0], rad_q[SQ_BITS-1:SQ_BITS-2]};
		strial = 26'({root_q, 2'b01});
		drem_n = {drem_q, dv_q[QUOT_BITS-1]};
		wq     = (dv_q > ONE_Q16) ? dv_q - ONE_Q16 : '0;
		acc_sum = (DENS_BITS+1)'(dens_q) + (DENS_BITS+1)'(weight_q);
		diff   = (dens_q >= base_q) ? dens_q - base_q : base_q - dens_q;
		prod_r = 57'(prod_s) + 57'h0FFFF;
		mag    = neg_q ? prod_r[56:16] : 41'(prod_s[55:16]);
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (in_acc && cmd == CMD_QUERY) begin
					st_d = slot_ok ? ST_ME : ST_OUT;
				end
			end
			ST_ME:   st_d = (ram_rdata[1:0] == KIND_GHOST) ? ST_OUT : ST_RD;
			ST_RD:   st_d = ST_CHK;
			ST_CHK:  st_d = skip ? ST_ACC : ST_SUM;
			ST_SUM: begin
				if (d2 >= (SQ_BITS+1)'(r2_q) || d2 == '0) begin
					st_d = ST_ACC;
				end else begin
					st_d = ST_SQRT;
				end
			end
			ST_SQRT: st_d = (scnt_q == SQ_LAST) ? ST_DIV : ST_SQRT;
			ST_DIV:  st_d = (dcnt_q == DIV_LAST) ? ST_WGT : ST_DIV;
			ST_WGT:  st_d = ST_ACC;
			ST_ACC:  st_d = (j_q + 1'b1 == count_q) ? ST_FIN : ST_RD;
			ST_FIN:  st_d = ST_SRC;
			ST_SRC:  st_d = ST_OUT;
			ST_OUT:  st_d = (!out_valid_q || !out_stall) ? ST_IDLE : ST_OUT;
			default: st_d = ST_IDLE;
		endcase
	end

	// handshake and memory control
	always_comb begin
		in_stall  = (st_q != ST_IDLE);
		cfg_ready = (st_q == ST_IDLE);
		ram_we    = in_acc && cmd == CMD_APPEND && (32'(count_q) < 32'(MAX_PARTICLES));
		ram_waddr = count_q[AW-1:0];
		ram_wdata = {pos_x, pos_y, kind};
		ram_raddr = (st_q == ST_IDLE) ? slot_w[AW-1:0] : j_q[AW-1:0];
	end

	// state, count, configuration and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			radius_q    <= RADIUS_RST;
			base_q      <= BASE_DENS_RST;
			thr_q       <= SURF_THR_RST;
			gain_q      <= GAIN_RST;
		end else begin
			st_q <= st_d;
			if (in_acc && cmd == CMD_CLEAR) begin
				count_q <= '0;
			end else if (ram_we) begin
				count_q <= count_q + 1'b1;
			end
			if (st_q == ST_OUT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_RADIUS:    radius_q <= cfg_data[RADIUS_BITS-1:0];
					REG_BASE_DENS: base_q   <= cfg_data[DENS_BITS-1:0];
					REG_SURF_THR:  thr_q    <= cfg_data[DENS_BITS-1:0];
					REG_GAIN:      gain_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// query datapath
	always_ff @(posedge clk) begin
		r2_q <= radius_q * radius_q;
		unique case (st_q)
			ST_IDLE: begin
				slot_q <= slot_w[AW-1:0];
				dens_q <= '0;
				cls_q  <= CLS_NONE;
				src_q  <= '0;
				bad_q  <= !slot_ok;
				j_q    <= '0;
			end
			ST_ME: begin
				me_x_q    <= ram_rdata[EW-1:P+2];
				me_y_q    <= ram_rdata[P+1:2];
				me_kind_q <= ram_rdata[1:0];
			end
			ST_CHK: begin
				sqx_s2   <= ax_w[RADIUS_BITS-1:0] * ax_w[RADIUS_BITS-1:0];
				sqy_s2   <= ay_w[RADIUS_BITS-1:0] * ay_w[RADIUS_BITS-1:0];
				weight_q <= '0;
			end
			ST_SUM: begin
				weight_q <= (d2 == '0 && d2 < (SQ_BITS+1)'(r2_q)) ? DENS_MAX : '0;
				rad_q    <= d2[SQ_BITS-1:0];
				srem_q   <= '0;
				root_q   <= '0;
				scnt_q   <= '0;
			end
			ST_SQRT: begin
				// one root bit per cycle
				rad_q  <= {rad_q[SQ_BITS-3:0], 2'b00};
				scnt_q <= scnt_q + 1'b1;
				if (srem_n >= strial) begin
					srem_q <= srem_n - strial;
					root_q <= {root_q[RADIUS_BITS-2:0], 1'b1};
				end else begin
					srem_q <= srem_n;
					root_q <= {root_q[RADIUS_BITS-2:0], 1'b0};
				end
				if (scnt_q == SQ_LAST) begin
					dv_q   <= {radius_q, 16'h0000};
					drem_q <= '0;
					dcnt_q <= '0;
				end
			end
			ST_DIV: begin
				// restoring divide, one quotient bit per cycle
				dcnt_q <= dcnt_q + 1'b1;
				if (drem_n >= 25'(root_q)) begin
					drem_q <= 24'(drem_n - 25'(root_q));
					dv_q   <= {dv_q[QUOT_BITS-2:0], 1'b1};
				end else begin
					drem_q <= drem_n[23:0];
					dv_q   <= {dv_q[QUOT_BITS-2:0], 1'b0};
				end
			end
			ST_WGT: begin
				weight_q <= (wq > QUOT_BITS'(DENS_MAX)) ? DENS_MAX : wq[DENS_BITS-1:0];
			end
			ST_ACC: begin
				dens_q <= acc_sum[DENS_BITS] ? DENS_MAX : acc_sum[DENS_BITS-1:0];
				j_q    <= j_q + 1'b1;
			end
			ST_FIN: begin
				// classify and form the source product
				neg_q  <= dens_q < base_q;
				prod_s <= gain_q * diff;
				if (me_kind_q == KIND_DUMMY) begin
					cls_q <= CLS_NONE;
				end else if (dens_q < thr_q) begin
					cls_q <= CLS_SURFACE;
				end else begin
					cls_q <= CLS_INNER;
				end
			end
			ST_SRC: begin
				if (cls_q == CLS_INNER) begin
					src_q <= neg_q ? -SRC_BITS'(mag) : SRC_BITS'(mag);
				end else begin
					src_q <= '0;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					density_q <= dens_q;
					class_q   <= cls_q;
					source_q  <= src_q;
					bad_out_q <= bad_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign density        = density_q;
	assign boundary_class = class_q;
	assign source_term    = source_q;
	assign bad_index      = bad_out_q;

	// checks
	`PNDC_CHECK(a_count_max, 32'(count_q) <= 32'(MAX_PARTICLES))
	`PNDC_IMPLY(a_bad_zero, out_valid && bad_index, density == '0 && source_term == '0)
	`PNDC_IMPLY(a_src_inner, out_valid && boundary_class != CLS_INNER, source_term == '0)
	`PNDC_NEXT(a_load_valid, st_q == ST_OUT && !out_stall, out_valid)

endmodule
`default_nettype wire
